### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

### rtl/kmh_pkg.sv
// Package: widths, constants, hash multipliers, job and result types for the k-mer min hash block
package kmh_pkg;
	localparam int MAX_KMER = 15;
	localparam int MAX_READ = 255;
	localparam int QDEPTH = 2;
	localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] FM_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FM_C2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [1:0] REG_KMER_LENGTH = 2'd0;

	typedef struct packed {
		logic [MAX_KMER*8-1:0] win;
		logic [3:0] len;
		logic [31:0] seed;
		logic [7:0] start;
		logic has_win;
		logic last;
	} job_t;

	typedef struct packed {
		logic [31:0] min_hash_value;
		logic [7:0] min_position;
		logic no_window;
	} res_t;
endpackage

### rtl/kmh_if.sv
// Valid/ready channel interfaces for requests and results
interface kmh_in_if;
	import kmh_pkg::*;
	logic valid;
	logic ready;
	logic [7:0] base_byte;
	logic [31:0] hash_seed;
	logic last_base;
	modport source (output valid, base_byte, hash_seed, last_base, input ready);
	modport sink (input valid, base_byte, hash_seed, last_base, output ready);
endinterface

interface kmh_out_if;
	logic valid;
	logic ready;
	logic [31:0] min_hash_value;
	logic [7:0] min_position;
	logic no_window;
	modport source (output valid, min_hash_value, min_position, no_window, input ready);
	modport sink (input valid, min_hash_value, min_position, no_window, output ready);
endinterface

### rtl/kmer_murmur_min_hash.sv
// Top level: k-mer min hash with APB register and stream channels
// One byte is accepted per cycle while the two-entry queue has room. Each full
// window is hashed in the back end by one shared 64-bit multiplier: a byte whose
// window is eight bytes or shorter takes six products, a longer window eight
// products, and a byte without a window none. The last byte of a read also passes
// through the output state, which waits while the previous result is not taken.
// The back end sets the sustained rate.
module kmer_murmur_min_hash (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	kmh_in_if.sink req,
	kmh_out_if.source res
);
	import kmh_pkg::*;
	logic [3:0] klen_q;
	logic q_full, q_push, q_valid, q_pop;
	job_t q_in, q_out;
	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == {REG_KMER_LENGTH[1:0]}) ? {28'd0, klen_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) klen_q <= 4'd6;
		else if (psel && penable && pwrite && paddr[1:0] == {REG_KMER_LENGTH[1:0]})
			klen_q <= pwdata[3:0];
	end
	kmh_front u_front (.clk(clk), .arst_n(arst_n), .req(req), .kmer_length(klen_q),
		.q_full(q_full), .q_push(q_push), .q_job(q_in));
	kmh_queue u_queue (.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_in),
		.full(q_full), .pop(q_pop), .valid(q_valid), .dout(q_out));
	kmh_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_job(q_out),
		.q_pop(q_pop), .res(res));
endmodule

### rtl/kmh_mul64.sv
// Multi-cycle 64x64 low-word multiplier, 32x32 partial products
module kmh_mul64 (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] a,
	input logic [63:0] b,
	output logic done,
	output logic [63:0] p
);
	import kmh_pkg::*;
	typedef enum logic [3:0] {
		M_IDLE = 4'b0001, M_P0 = 4'b0010, M_P1 = 4'b0100, M_P2 = 4'b1000
	} mst_t;
	mst_t st_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] ma, mb;
	logic [63:0] prod_q;
	always_comb begin
		case (st_q)
			M_P0: begin ma = a_q[31:0]; mb = b_q[31:0]; end
			M_P1: begin ma = a_q[63:32]; mb = b_q[31:0]; end
			default: begin ma = a_q[31:0]; mb = b_q[63:32]; end
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				M_IDLE: if (start) st_q <= M_P0;
				M_P0: st_q <= M_P1;
				M_P1: st_q <= M_P2;
				M_P2: begin st_q <= M_IDLE; done <= 1'b1; end
				default: st_q <= M_IDLE;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (st_q == M_IDLE && start) begin
			a_q <= a;
			b_q <= b;
		end
		case (st_q)
			M_P0: acc_q <= 64'd0;
			M_P1: acc_q <= prod_q;
			M_P2: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			default: acc_q <= acc_q;
		endcase
	end
	assign p = acc_q + {prod_q[31:0], 32'd0};
endmodule

### rtl/kmh_front.sv
// Front end: sliding window, byte count, seed latch, job issue
module kmh_front (
	input logic clk,
	input logic arst_n,
	kmh_in_if.sink req,
	input logic [3:0] kmer_length,
	input logic q_full,
	output logic q_push,
	output kmh_pkg::job_t q_job
);
	import kmh_pkg::*;
	logic [7:0] win_q [MAX_KMER];
	logic [7:0] cnt_q;
	logic [31:0] seed_q;
	logic [3:0] k;
	logic [31:0] seed_c;
	logic [7:0] nw [MAX_KMER];
	logic [8:0] idx1;
	assign k = (kmer_length == 4'd0) ? 4'd1 : kmer_length;
	assign req.ready = !q_full;
	assign q_push = req.valid && req.ready;
	assign seed_c = (cnt_q == 8'd0) ? req.hash_seed : seed_q;
	assign idx1 = {1'b0, cnt_q} + 9'd1;
	always_comb begin
		for (int i = 0; i < MAX_KMER - 1; i++) nw[i] = win_q[i+1];
		nw[MAX_KMER-1] = req.base_byte;
		q_job.win = '0;
		for (int j = 0; j < MAX_KMER; j++)
			if (j < 32'(k)) q_job.win[j*8 +: 8] = nw[MAX_KMER - 32'(k) + j];
		q_job.len = k;
		q_job.seed = seed_c;
		q_job.has_win = idx1 >= {5'd0, k};
		q_job.start = 8'(idx1 - {5'd0, k});
		q_job.last = req.last_base;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			seed_q <= '0;
			for (int i = 0; i < MAX_KMER; i++) win_q[i] <= '0;
		end else if (q_push) begin
			if (req.last_base) begin
				cnt_q <= '0;
				seed_q <= '0;
				for (int i = 0; i < MAX_KMER; i++) win_q[i] <= '0;
			end else begin
				for (int i = 0; i < MAX_KMER; i++) win_q[i] <= nw[i];
				seed_q <= seed_c;
				if (cnt_q != 8'(MAX_READ)) cnt_q <= cnt_q + 8'd1;
			end
		end
	end
endmodule

### rtl/kmh_back.sv
// Back end: sequenced murmur hash, running minimum, result register
module kmh_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input kmh_pkg::job_t q_job,
	output logic q_pop,
	kmh_out_if.source res
);
	import kmh_pkg::*;
	typedef enum logic [14:0] {
		S_IDLE = 15'h0001, S_K1A = 15'h0002, S_K1B = 15'h0004, S_K2A = 15'h0008,
		S_K2B = 15'h0010, S_MIX = 15'h0020, S_F1 = 15'h0040, S_F1M = 15'h0080,
		S_F2 = 15'h0100, S_F2M = 15'h0200, S_H1D = 15'h0400, S_G1M = 15'h0800,
		S_G2M = 15'h1000, S_CMP = 15'h2000, S_OUT = 15'h4000
	} st_t;
	st_t st_q;
	job_t job_q;
	logic [63:0] k2_q, h1_q, h2_q, x_q, f1_q, f2_q;
	logic mul_st;
	logic mstart;
	logic busy_q;
	logic [63:0] ma, mb, mp;
	logic mdone;
	logic [31:0] best_q;
	logic [7:0] pos_q;
	logic bval_q;
	logic [31:0] h32;
	logic res_free;
	kmh_mul64 u_mul (.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.done(mdone), .p(mp));
	always_comb begin
		ma = x_q;
		mb = MM_C1;
		mul_st = 1'b1;
		case (st_q)
			S_K1A: mb = MM_C1;
			S_K1B: mb = MM_C2;
			S_K2A: mb = MM_C2;
			S_K2B: mb = MM_C1;
			S_F1M, S_F2M: mb = FM_C1;
			S_G1M, S_G2M: mb = FM_C2;
			default: mul_st = 1'b0;
		endcase
	end
	assign mstart = mul_st && !busy_q;
	assign res_free = !res.valid || res.ready;
	assign q_pop = (st_q == S_IDLE) && q_valid;
	assign h32 = h1_q[31:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (mdone) busy_q <= 1'b0;
		else if (mstart) busy_q <= 1'b1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res.valid <= 1'b0;
			res.no_window <= 1'b0;
			res.min_hash_value <= '0;
			res.min_position <= '0;
			bval_q <= 1'b0;
			best_q <= '1;
			pos_q <= '0;
		end else begin
			res.valid <= (st_q == S_OUT && res_free) || (res.valid && !res.ready);
			case (st_q)
				S_IDLE: if (q_valid) st_q <= q_job.has_win ? S_K1A : S_CMP;
				S_K1A: if (mdone) st_q <= S_K1B;
				S_K1B: if (mdone) st_q <= (job_q.len > 4'd8) ? S_K2A : S_MIX;
				S_K2A: if (mdone) st_q <= S_K2B;
				S_K2B: if (mdone) st_q <= S_MIX;
				S_MIX: st_q <= S_F1;
				S_F1: st_q <= S_F1M;
				S_F1M: if (mdone) st_q <= S_F2;
				S_F2: st_q <= S_F2M;
				S_F2M: if (mdone) st_q <= S_G1M;
				S_G1M: if (mdone) st_q <= S_G2M;
				S_G2M: if (mdone) st_q <= S_H1D;
				S_H1D: st_q <= S_CMP;
				S_CMP: begin
					if (job_q.has_win && (!bval_q || h32 < best_q)) begin
						best_q <= h32;
						pos_q <= job_q.start;
						bval_q <= 1'b1;
					end
					st_q <= job_q.last ? S_OUT : S_IDLE;
				end
				S_OUT: if (res_free) begin
					res.no_window <= !bval_q;
					res.min_hash_value <= bval_q ? best_q : 32'hFFFFFFFF;
					res.min_position <= bval_q ? pos_q : 8'd0;
					bval_q <= 1'b0;
					best_q <= '1;
					pos_q <= '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			x_q <= q_job.win[63:0];
			k2_q <= {8'd0, q_job.win[MAX_KMER*8-1:64]};
			h1_q <= {32'd0, q_job.seed};
			h2_q <= {32'd0, q_job.seed};
		end
		if (mdone) begin
			case (st_q)
				S_K1A: x_q <= {mp[32:0], mp[63:33]};
				S_K1B: begin
					h1_q <= h1_q ^ mp;
					x_q <= k2_q;
				end
				S_K2A: x_q <= {mp[30:0], mp[63:31]};
				S_K2B: h2_q <= h2_q ^ mp;
				S_F1M: begin f1_q <= mp; x_q <= f2_q; end
				S_F2M: begin f2_q <= mp; x_q <= f1_q ^ (f1_q >> 33); end
				S_G1M: begin f1_q <= mp; x_q <= f2_q ^ (f2_q >> 33); end
				S_G2M: f2_q <= mp;
				default: ;
			endcase
		end
		case (st_q)
			S_MIX: begin
				h1_q <= (h1_q ^ {60'd0, job_q.len}) + (h2_q ^ {60'd0, job_q.len});
				h2_q <= h2_q ^ {60'd0, job_q.len};
			end
			S_F1: begin
				h2_q <= h2_q + h1_q;
				x_q <= h1_q ^ (h1_q >> 33);
				f2_q <= (h2_q + h1_q) ^ ((h2_q + h1_q) >> 33);
			end
			S_H1D: h1_q <= (f1_q ^ (f1_q >> 33)) + (f2_q ^ (f2_q >> 33));
			default: ;
		endcase
	end
endmodule

### rtl/kmh_queue.sv
// Two-entry job queue between front and back
module kmh_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input kmh_pkg::job_t din,
	output logic full,
	input logic pop,
	output logic valid,
	output kmh_pkg::job_t dout
);
	import kmh_pkg::*;
	job_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full = cnt_q == 2'(QDEPTH);
	assign valid = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];
	always_ff @(posedge clk) if (push) mem_q[wp_q] <= din;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### rtl/kmh_checker.sv
// Port-level checker for the k-mer min hash block, bound to the top level
`include "assert_macros.svh"
module kmh_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [31:0] min_hash_value,
	input logic [7:0] min_position,
	input logic no_window,
	input logic pready
);
	`CHK_IMPL(a_nowin_val, clk, arst_n, res_valid && no_window, min_hash_value == 32'hFFFFFFFF)
	`CHK_IMPL(a_nowin_pos, clk, arst_n, res_valid && no_window, min_position == 8'd0)
	`CHK_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(min_hash_value))
	`CHK_IMPL(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind kmer_murmur_min_hash kmh_checker u_chk (.clk(clk), .arst_n(arst_n),
	.res_valid(res.valid), .res_ready(res.ready), .min_hash_value(res.min_hash_value),
	.min_position(res.min_position), .no_window(res.no_window), .pready(pready));
